// File: sv/grid_rank_coordinate_mapper_assert.svh
// ----------------------------------------------------------------------------
// grid rank coordinate mapper assertion macros
// concurrent check helpers used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef GRID_RANK_COORDINATE_MAPPER_ASSERT_SVH
`define GRID_RANK_COORDINATE_MAPPER_ASSERT_SVH

// check sampled on the rising clock edge, masked while reset is high
`define GRCM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check sampled on the rising clock edge, active during reset too
`define GRCM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/grcm_pkg.sv
// ----------------------------------------------------------------------------
// grcm_pkg
// shared types and constants of the grid rank coordinate mapper
// ----------------------------------------------------------------------------
package grcm_pkg;

   localparam int MAX_DIMS       = 4;
   localparam int RANK_WIDTH     = 16;
   localparam int DIVIDEND_W     = 2 * RANK_WIDTH;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = DIVIDEND_W / BITS_PER_STAGE;

   typedef logic [RANK_WIDTH-1:0] word_type;
   typedef logic [RANK_WIDTH:0]   grid_type;
   typedef logic [DIVIDEND_W-1:0] dividend_type;

   // grid size saturates here, rank differences never reach it
   localparam grid_type GRID_SAT = grid_type'(1) << RANK_WIDTH;

   typedef enum logic {
      OP_DECODE = 1'b0,
      OP_ENCODE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      CSR_DIM_COUNT   = 3'd0,
      CSR_SIZE_DIM0   = 3'd1,
      CSR_SIZE_DIM1   = 3'd2,
      CSR_SIZE_DIM2   = 3'd3,
      CSR_SIZE_DIM3   = 3'd4,
      CSR_START_RANK  = 3'd5,
      CSR_TOTAL_RANKS = 3'd6
   } csr_index_type;

   // payload that rides along the divider chain
   typedef struct packed {
      op_type   op;
      logic     in_grid;
      logic     range_err;
      word_type rank_out;
      word_type coord3;
      word_type coord2;
   } side_type;

endpackage

// File: sv/grid_rank_coordinate_mapper.sv
// ----------------------------------------------------------------------------
// grid_rank_coordinate_mapper
// rank to grid coordinate decode and coordinate to rank encode
// ----------------------------------------------------------------------------
// use:
//   req_ channel carries one request per transfer, tuser selects the op:
//   decode splits a rank into up to four row-major coordinates relative to
//   start_rank modulo total_ranks and reports in_grid; encode folds the
//   coordinates into start_rank plus the mixed-radix sum and flags any
//   coordinate at or above its dimension size.
//   rsp_ channel returns exactly one result transfer per request, in order.
//   csr_ port writes the seven setup registers; write them only while the block is idle, the block does not enforce it.
// pipeline:
//   request transfer to rsp_tvalid passes three stages of
//   multiply-add and grid size product, four 16-stage dividers (modulo by
//   total_ranks, then divide by the sizes of dimensions three, two and one),
//   and the result register.
//   throughput one transfer per cycle while no result waits with rsp_tready low.
// reset:
//   synchronous; empties the pipeline and loads one dimension of size one,
//   start rank zero and a machine of one processor.
// stall:
//   while a result waits and rsp_tready is low the whole pipeline holds and
//   req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "grid_rank_coordinate_mapper_assert.svh"

module grid_rank_coordinate_mapper (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // rank_in, coord_in0, coord_in1, coord_in2, coord_in3
   input  logic        req_tuser,   // op
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // rank_out, coord_out0..3, in_grid,
                                    // coord_range_error, zero pad
   // setup registers
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import grcm_pkg::*;

   typedef struct packed {
      op_type   op;
      word_type rank;
      word_type c2;
      word_type c3;
      word_type acc;
      logic     err;
      grid_type grid;
   } pre_type;

   // setup registers
   logic [2:0] dim_count_ff;
   word_type   size_ff [MAX_DIMS];
   word_type   start_ff;
   word_type   total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= 3'd1;
         for (int i = 0; i < MAX_DIMS; i++) size_ff[i] <= word_type'(1);
         start_ff     <= '0;
         total_ff     <= word_type'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DIM_COUNT:   dim_count_ff <= csr_wdata[2:0];
            CSR_SIZE_DIM0:   size_ff[0]   <= csr_wdata;
            CSR_SIZE_DIM1:   size_ff[1]   <= csr_wdata;
            CSR_SIZE_DIM2:   size_ff[2]   <= csr_wdata;
            CSR_SIZE_DIM3:   size_ff[3]   <= csr_wdata;
            CSR_START_RANK:  start_ff     <= csr_wdata;
            CSR_TOTAL_RANKS: total_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective dimension count and sizes, unused dimensions act as size one
   logic [2:0] dims;
   word_type   sz [MAX_DIMS];
   word_type   tot_eff;

   always_comb begin
      if (dim_count_ff == 3'd0) dims = 3'd1;
      else if (dim_count_ff > 3'(MAX_DIMS)) dims = 3'(MAX_DIMS);
      else dims = dim_count_ff;
      for (int i = 0; i < MAX_DIMS; i++) begin
         sz[i] = (dims > 3'(i) && size_ff[i] != '0) ? size_ff[i] : word_type'(1);
      end
      tot_eff = (total_ff == '0) ? word_type'(1) : total_ff;
   end

   function automatic grid_type grid_sat(grid_type p, word_type s);
      logic [2*RANK_WIDTH:0] prod;
      prod = p * s;
      return (prod > (2*RANK_WIDTH+1)'(GRID_SAT)) ? GRID_SAT : prod[RANK_WIDTH:0];
   endfunction

   // global advance: hold everything while a result waits unaccepted
   logic rsp_valid_ff;
   logic en;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // stage a: mask unused coordinates, range check, first multiply-add
   word_type c_in [MAX_DIMS];
   word_type c_m  [MAX_DIMS];
   logic     err_in;
   pre_type  a_in;
   logic     a_valid_ff;
   pre_type  a_ff;

   always_comb begin
      err_in = 1'b0;
      for (int i = 0; i < MAX_DIMS; i++) begin
         c_in[i] = req_tdata[RANK_WIDTH*(i+1) +: RANK_WIDTH];
         c_m[i]  = (dims > 3'(i)) ? c_in[i] : '0;
         if (dims > 3'(i) && c_in[i] >= sz[i]) err_in = 1'b1;
      end
      a_in.op   = op_type'(req_tuser);
      a_in.rank = req_tdata[RANK_WIDTH-1:0];
      a_in.c2   = c_m[2];
      a_in.c3   = c_m[3];
      a_in.acc  = word_type'(c_m[0] * sz[1]) + c_m[1];
      a_in.err  = err_in;
      a_in.grid = grid_sat(grid_type'(sz[0]), sz[1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_tvalid;
      end
      if (en) a_ff <= a_in;
   end

   // stage b: second multiply-add
   pre_type b_in;
   logic    b_valid_ff;
   pre_type b_ff;

   always_comb begin
      b_in      = a_ff;
      b_in.acc  = word_type'(a_ff.acc * sz[2]) + a_ff.c2;
      b_in.grid = grid_sat(a_ff.grid, sz[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= a_valid_ff;
      end
      if (en) b_ff <= b_in;
   end

   // stage c: last multiply-add plus start, grid test, modulo dividend
   grid_type     grid_c;
   side_type     c_side_in;
   dividend_type c_x_in;
   logic         c_valid_ff;
   side_type     c_side_ff;
   dividend_type c_x_ff;

   always_comb begin
      grid_c              = grid_sat(b_ff.grid, sz[3]);
      c_side_in.op        = b_ff.op;
      c_side_in.coord3    = '0;
      c_side_in.coord2    = '0;
      if (b_ff.op == OP_ENCODE) begin
         c_side_in.in_grid   = 1'b0;
         c_side_in.range_err = b_ff.err;
         c_side_in.rank_out  = word_type'(b_ff.acc * sz[3]) + b_ff.c3 + start_ff;
      end else begin
         c_side_in.in_grid   = (b_ff.rank >= start_ff) &&
                               (grid_type'(b_ff.rank - start_ff) < grid_c);
         c_side_in.range_err = 1'b0;
         c_side_in.rank_out  = '0;
      end
      // nonnegative value congruent to rank - start modulo the machine size
      c_x_in = {tot_eff, word_type'(0)} + dividend_type'(b_ff.rank)
               - dividend_type'(start_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= b_valid_ff;
      end
      if (en) begin
         c_side_ff <= c_side_in;
         c_x_ff    <= c_x_in;
      end
   end

   // divider chain: relative rank, then peel dimensions three, two, one
   logic         d0_valid, d1_valid, d2_valid, d3_valid;
   dividend_type d1_quo, d2_quo, d3_quo;
   word_type     d0_rem, d1_rem, d2_rem, d3_rem;
   side_type     d0_side, d1_side, d2_side, d3_side;
   side_type     d1_side_upd, d2_side_upd;

   grcm_div u_div_rel (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_valid_ff),
      .dividend  (c_x_ff),
      .divisor   (tot_eff),
      .in_side   (c_side_ff),
      .out_valid (d0_valid),
      .quotient  (),
      .remainder (d0_rem),
      .out_side  (d0_side)
   );

   grcm_div u_div_dim3 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d0_valid),
      .dividend  (dividend_type'(d0_rem)),
      .divisor   (sz[3]),
      .in_side   (d0_side),
      .out_valid (d1_valid),
      .quotient  (d1_quo),
      .remainder (d1_rem),
      .out_side  (d1_side)
   );

   always_comb begin
      d1_side_upd        = d1_side;
      d1_side_upd.coord3 = d1_rem;
   end

   grcm_div u_div_dim2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d1_valid),
      .dividend  (d1_quo),
      .divisor   (sz[2]),
      .in_side   (d1_side_upd),
      .out_valid (d2_valid),
      .quotient  (d2_quo),
      .remainder (d2_rem),
      .out_side  (d2_side)
   );

   always_comb begin
      d2_side_upd        = d2_side;
      d2_side_upd.coord2 = d2_rem;
   end

   grcm_div u_div_dim1 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d2_valid),
      .dividend  (d2_quo),
      .divisor   (sz[1]),
      .in_side   (d2_side_upd),
      .out_valid (d3_valid),
      .quotient  (d3_quo),
      .remainder (d3_rem),
      .out_side  (d3_side)
   );

   // result register, coordinates cleared for encode
   logic [87:0] rsp_data_in;
   logic [87:0] rsp_data_ff;

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[15:0] = d3_side.rank_out;
      if (d3_side.op == OP_DECODE) begin
         rsp_data_in[31:16] = d3_quo[RANK_WIDTH-1:0];
         rsp_data_in[47:32] = d3_rem;
         rsp_data_in[63:48] = d3_side.coord2;
         rsp_data_in[79:64] = d3_side.coord3;
      end
      rsp_data_in[80] = d3_side.in_grid;
      rsp_data_in[81] = d3_side.range_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= d3_valid;
      end
      if (en) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `GRCM_ASSERT(a_req_enters, (req_tvalid && req_tready) |=> a_valid_ff,
                "accepted request missing from first stage")
   `GRCM_ASSERT(a_stall_holds, !en |=> ($stable(c_x_ff) && $stable(c_valid_ff)),
                "divider input changed during stall")
   `GRCM_ASSERT(a_flags_exclusive, rsp_valid_ff |-> !(rsp_data_ff[80] && rsp_data_ff[81]),
                "in_grid and range error both set")
   `GRCM_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid_ff,
                "result valid right after reset")

endmodule

// File: sv/grcm_div.sv
// ----------------------------------------------------------------------------
// grcm_div
// pipelined restoring divider, two quotient bits per stage, global stall
// ----------------------------------------------------------------------------
module grcm_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  grcm_pkg::dividend_type dividend,
   input  grcm_pkg::word_type     divisor,
   input  grcm_pkg::side_type     in_side,
   output logic                   out_valid,
   output grcm_pkg::dividend_type quotient,
   output grcm_pkg::word_type     remainder,
   output grcm_pkg::side_type     out_side
);
   import grcm_pkg::*;

   typedef struct packed {
      word_type     rem;
      dividend_type quo;
   } div_state_type;

   function automatic div_state_type div_step(div_state_type st, word_type d);
      div_state_type     r;
      logic [RANK_WIDTH:0] t;
      r = st;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
         t = {r.rem, r.quo[DIVIDEND_W-1]};
         if (t >= {1'b0, d}) begin
            r.rem = word_type'(t - {1'b0, d});
            r.quo = {r.quo[DIVIDEND_W-2:0], 1'b1};
         end else begin
            r.rem = t[RANK_WIDTH-1:0];
            r.quo = {r.quo[DIVIDEND_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   logic          val_ff  [DIV_STAGES];
   div_state_type st_ff   [DIV_STAGES];
   side_type      side_ff [DIV_STAGES];
   div_state_type st_in   [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      if (g == 0) begin : g_first
         always_comb begin
            st_in[g] = div_step('{rem: '0, quo: dividend}, divisor);
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               val_ff[g] <= 1'b0;
            end else if (en) begin
               val_ff[g] <= in_valid;
            end
            if (en) begin
               st_ff[g]   <= st_in[g];
               side_ff[g] <= in_side;
            end
         end
      end else begin : g_rest
         always_comb begin
            st_in[g] = div_step(st_ff[g-1], divisor);
         end
         always_ff @(posedge clock) begin
            if (reset) begin
               val_ff[g] <= 1'b0;
            end else if (en) begin
               val_ff[g] <= val_ff[g-1];
            end
            if (en) begin
               st_ff[g]   <= st_in[g];
               side_ff[g] <= side_ff[g-1];
            end
         end
      end
   end

   assign out_valid = val_ff[DIV_STAGES-1];
   assign quotient  = st_ff[DIV_STAGES-1].quo;
   assign remainder = st_ff[DIV_STAGES-1].rem;
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule
